// ===== rtl/qmn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared widths and types for the normalised quaternion product pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int unsigned COMP_W = 16;
    localparam int unsigned PROD_W = 34;   // signed exact product component
    localparam int unsigned MAG_W  = 33;   // |r| fits in 33 bits
    localparam int unsigned T_W    = 30;   // block-floating magnitude
    localparam int unsigned SQ_W   = 62;   // sum of squares
    localparam int unsigned RT_W   = 31;   // integer square root

    typedef logic [T_W-1:0] t_mag4 [4];

endpackage

// ===== rtl/qmn_sqrt.sv =====
// ----------------------------------------------------------------------------
// qmn_sqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module qmn_sqrt #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [qmn_pkg::SQ_W-1:0] i_rad,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_vld,
    output logic [qmn_pkg::RT_W-1:0] o_root,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int unsigned N  = qmn_pkg::RT_W;
    localparam int unsigned RW = qmn_pkg::SQ_W + 2;

    logic [N:0]          r_vld;
    logic [RW-1:0]       r_rem  [N+1];
    logic [N-1:0]        r_root [N+1];
    logic [SIDE_W-1:0]   r_side [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {2'b00, i_rad};
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int unsigned B = N - 1 - k;
        logic [RW-1:0] trial;
        assign trial = ({{(RW-N){1'b0}}, r_root[k]} << (B + 1))
                     + ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
            if (r_rem[k] >= trial) begin
                r_rem[k+1]  <= r_rem[k] - trial;
                r_root[k+1] <= r_root[k] | (N'(1) << B);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_root[N];
    assign o_side = r_side[N];

endmodule

// ===== rtl/qmn_div.sv =====
// ----------------------------------------------------------------------------
// qmn_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module qmn_div #(
    parameter int unsigned NUM_W  = 46,
    parameter int unsigned DEN_W  = 31,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned RW = DEN_W + 1;

    logic [NUM_W:0]      r_vld;
    logic [RW-1:0]       r_rem  [NUM_W+1];
    logic [NUM_W-1:0]    r_num  [NUM_W+1];
    logic [DEN_W-1:0]    r_den  [NUM_W+1];
    logic [SIDE_W-1:0]   r_side [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_W-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [RW-1:0] sh;
        assign sh = {r_rem[k][RW-2:0], r_num[k][NUM_W-1]};
        always_ff @(posedge i_clk) begin
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
            if (sh >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= sh - {1'b0, r_den[k]};
                r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= sh;
                r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[NUM_W];
    assign o_quo  = r_num[NUM_W];
    assign o_side = r_side[NUM_W];

endmodule

// ===== rtl/quaternion_multiply_normalize_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_core
// Hamilton product of two Q2.14 quaternions scaled to unit length.
// ----------------------------------------------------------------------------
// Usage: present a and b on the i_ ports and pulse start. busy is always
// low, so a beat is taken every cycle a start is seen. Each beat yields
// one result, shown for one cycle with o_valid high, carrying p_w..p_z and
// o_degenerate (all-zero product: zeros out, flag set).
// Pipeline: products, sums, magnitude, block shift and squares, then the
// square root, then one divider stage per quotient bit and one output
// register. Throughput: one beat per cycle; every unit is fully pipelined.
// Results leave in input order. The receiver cannot stall; the block never
// holds results back. Synchronous reset clears all valid bits; data in
// flight is dropped.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_core #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    output logic        o_valid,
    output logic signed [15:0] o_p_w,
    output logic signed [15:0] o_p_x,
    output logic signed [15:0] o_p_y,
    output logic signed [15:0] o_p_z,
    output logic        o_degenerate
);

    localparam int unsigned PW = qmn_pkg::PROD_W;
    localparam int unsigned MW = qmn_pkg::MAG_W;
    localparam int unsigned TW = qmn_pkg::T_W;
    localparam int unsigned NUM_W = TW + FRAC_BITS + 1;
    localparam int unsigned SIDE_W = 4 + 1 + 4 * TW;

    assign busy = 1'b0;

    // stage 1: sixteen products
    logic               r_v1;
    logic signed [31:0] r_pr [16];
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    assign a = '{i_a_w, i_a_x, i_a_y, i_a_z};
    assign b = '{i_b_w, i_b_x, i_b_y, i_b_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_pr[4*i+j] <= a[i] * b[j];
            end
        end
    end

    // stage 2: component sums
    logic                 r_v2;
    logic signed [PW-1:0] r_r [4];
    function automatic logic signed [PW-1:0] ext(input logic signed [31:0] v);
        return PW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_r[0] <= ext(r_pr[0])  - ext(r_pr[5])  - ext(r_pr[10]) - ext(r_pr[15]);
        r_r[1] <= ext(r_pr[1])  + ext(r_pr[4])  + ext(r_pr[11]) - ext(r_pr[14]);
        r_r[2] <= ext(r_pr[2])  - ext(r_pr[7])  + ext(r_pr[8])  + ext(r_pr[13]);
        r_r[3] <= ext(r_pr[3])  + ext(r_pr[6])  - ext(r_pr[9])  + ext(r_pr[12]);
    end

    // stage 3: magnitudes, signs, maximum
    logic          r_v3;
    logic [MW-1:0] r_m [4];
    logic [3:0]    r_s3;
    logic [MW-1:0] r_max;
    logic [MW-1:0] mg [4];
    logic [MW-1:0] mx01, mx23;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mg[i] = r_r[i][PW-1] ? MW'(-r_r[i]) : MW'(r_r[i]);
        end
        mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
        mx23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int i = 0; i < 4; i++) begin
            r_m[i]  <= mg[i];
            r_s3[i] <= r_r[i][PW-1];
        end
        r_max <= (mx01 > mx23) ? mx01 : mx23;
    end

    // stage 4: block shift (0..3), then squares in their own register
    logic          r_v4;
    logic [TW-1:0] r_t [4];
    logic [3:0]    r_s4;
    logic          r_dg4;
    logic [1:0]    sh;

    always_comb begin
        priority if (r_max[32]) sh = 2'd3;
        else if (r_max[31])     sh = 2'd2;
        else if (r_max[30])     sh = 2'd1;
        else                    sh = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        for (int i = 0; i < 4; i++) begin
            r_t[i] <= TW'(r_m[i] >> sh);
        end
        r_s4  <= r_s3;
        r_dg4 <= (r_max == '0);
    end

    logic          r_v5;
    logic [59:0]   r_sq [4];
    logic [TW-1:0] r_t5 [4];
    logic [3:0]    r_s5;
    logic          r_dg5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= r_t[i] * r_t[i];
        end
        r_t5  <= r_t;
        r_s5  <= r_s4;
        r_dg5 <= r_dg4;
    end

    logic [qmn_pkg::SQ_W-1:0] sum_sq;
    assign sum_sq = 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]) + 62'(r_sq[3]);

    logic [SIDE_W-1:0] side_in, side_rt;
    assign side_in = {r_s5, r_dg5, r_t5[0], r_t5[1], r_t5[2], r_t5[3]};

    logic                     rt_vld;
    logic [qmn_pkg::RT_W-1:0] root;

    qmn_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v5),
        .i_rad   (sum_sq),
        .i_side  (side_in),
        .o_vld   (rt_vld),
        .o_root  (root),
        .o_side  (side_rt)
    );

    // four dividers in lockstep; a zero root gets a dummy divisor of one
    logic [qmn_pkg::RT_W-1:0] den;
    assign den = (root == '0) ? qmn_pkg::RT_W'(1) : root;

    logic [NUM_W-1:0] q [4];
    logic [4:0]       dv_side [4];
    logic [3:0]       dv_vld;

    for (genvar i = 0; i < 4; i++) begin : g_div
        logic [TW-1:0]    ti;
        logic [NUM_W-1:0] num;
        assign ti  = side_rt[TW*(4-i)-1 -: TW];
        assign num = (NUM_W'(ti) << FRAC_BITS) + NUM_W'(root >> 1);
        qmn_div #(
            .NUM_W  (NUM_W),
            .DEN_W  (qmn_pkg::RT_W),
            .SIDE_W (5)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (rt_vld),
            .i_num   (num),
            .i_den   (den),
            .i_side  (side_rt[SIDE_W-1 -: 5]),
            .o_vld   (dv_vld[i]),
            .o_quo   (q[i]),
            .o_side  (dv_side[i])
        );
    end

    // output register: sign, saturation and zeroing of degenerate results
    logic signed [15:0] pv [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (dv_side[0][i+1]) begin
                pv[i] = (q[i] > NUM_W'(32768)) ? 16'sh8000 : 16'(-q[i]);
            end else begin
                pv[i] = (q[i] > NUM_W'(32767)) ? 16'sh7fff : 16'(q[i]);
            end
            if (dv_side[0][0]) begin
                pv[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_vld[0];
        end
        o_p_w        <= pv[0];
        o_p_x        <= pv[1];
        o_p_y        <= pv[2];
        o_p_z        <= pv[3];
        o_degenerate <= dv_side[0][0];
    end

    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld[0] == dv_vld[1] && dv_vld[2] == dv_vld[3] && dv_vld[0] == dv_vld[2])
        else $error("divider lanes out of step");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_p_w == 0 && o_p_x == 0 && o_p_y == 0 && o_p_z == 0)
        else $error("degenerate result not zero");
    a_root_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rt_vld && !side_rt[4*TW] |-> root != '0)
        else $error("zero root on non-degenerate beat");

endmodule
